[sv/assert_macros.svh]
// assertion macros shared by the cull test rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define AFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afc assertion failed");

// next-cycle implication, checked while out of reset
`define AFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afc assertion failed");

`endif

[sv/afc_pkg.sv]
// types and constants of the box-against-frustum cull test
`timescale 1ns / 1ps
package afc_pkg;

  localparam int NumPlanes  = 6;
  localparam int NumAxes    = 3;
  localparam int NumCorners = 8;
  localparam int NumStages  = 6;
  // aligns d from q8.8 to the q.24 of the coefficient products
  localparam int DShift     = 16;

  typedef logic signed [15:0] q88_t;   // input and coefficient, Q8.8
  typedef logic signed [16:0] sum_t;   // corner plus position, Q9.8
  typedef logic signed [32:0] world_t; // scale times sum, Q17.16
  typedef logic signed [48:0] term_t;  // coefficient times coordinate, Q25.24
  typedef logic signed [50:0] acc_t;   // plane sum and its partial sums

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_LEFT,
    REG_RIGHT,
    REG_BOTTOM,
    REG_TOP,
    REG_NEAR,
    REG_FAR
  } reg_idx_t;

  typedef struct packed {
    logic                        culling_enable;
    logic [NumPlanes-1:0][63:0]  planes;
  } cfg_t;

  // load enables of the six pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

endpackage

[sv/afc_ifs.sv]
// word channels of the cull test: object in, verdict out
`timescale 1ns / 1ps
interface afc_obj_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_z;
  logic signed [15:0] box_min_x;
  logic signed [15:0] box_min_y;
  logic signed [15:0] box_min_z;
  logic signed [15:0] box_max_x;
  logic signed [15:0] box_max_y;
  logic signed [15:0] box_max_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface afc_verdict_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink (input valid, culled, output ready);
endinterface

[sv/afc_cfg.sv]
// configuration registers: enable and six packed planes
`timescale 1ns / 1ps
module afc_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output afc_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.culling_enable <= 1'b1;
      cfg.planes         <= '0;
    end else if (cfg_wr_en) begin
      unique case (afc_pkg::reg_idx_t'(cfg_index))
        afc_pkg::REG_ENABLE: cfg.culling_enable <= cfg_data[0];
        afc_pkg::REG_LEFT:   cfg.planes[0] <= cfg_data;
        afc_pkg::REG_RIGHT:  cfg.planes[1] <= cfg_data;
        afc_pkg::REG_BOTTOM: cfg.planes[2] <= cfg_data;
        afc_pkg::REG_TOP:    cfg.planes[3] <= cfg_data;
        afc_pkg::REG_NEAR:   cfg.planes[4] <= cfg_data;
        afc_pkg::REG_FAR:    cfg.planes[5] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/afc_world.sv]
// stages one and two: box limits plus position, then times scale
`timescale 1ns / 1ps
module afc_world (
  input  logic              clk,
  input  afc_pkg::pipe_en_t pen,
  input  afc_pkg::q88_t     pos   [afc_pkg::NumAxes],
  input  afc_pkg::q88_t     scl   [afc_pkg::NumAxes],
  input  afc_pkg::q88_t     lo    [afc_pkg::NumAxes],
  input  afc_pkg::q88_t     hi    [afc_pkg::NumAxes],
  output afc_pkg::world_t   w_lo  [afc_pkg::NumAxes],
  output afc_pkg::world_t   w_hi  [afc_pkg::NumAxes]
);

  afc_pkg::sum_t sum_lo [afc_pkg::NumAxes];
  afc_pkg::sum_t sum_hi [afc_pkg::NumAxes];
  afc_pkg::q88_t scl_q  [afc_pkg::NumAxes];

  always_ff @(posedge clk) begin
    for (int a = 0; a < afc_pkg::NumAxes; a++) begin
      if (pen.s1) begin
        sum_lo[a] <= afc_pkg::sum_t'(lo[a]) + afc_pkg::sum_t'(pos[a]);
        sum_hi[a] <= afc_pkg::sum_t'(hi[a]) + afc_pkg::sum_t'(pos[a]);
        scl_q[a]  <= scl[a];
      end
      if (pen.s2) begin
        w_lo[a] <= afc_pkg::world_t'(scl_q[a]) * afc_pkg::world_t'(sum_lo[a]);
        w_hi[a] <= afc_pkg::world_t'(scl_q[a]) * afc_pkg::world_t'(sum_hi[a]);
      end
    end
  end

endmodule

[sv/afc_plane.sv]
// stages three to five for one plane: products, partial sums, corner signs
`timescale 1ns / 1ps
module afc_plane (
  input  logic                               clk,
  input  afc_pkg::pipe_en_t                  pen,
  input  logic [63:0]                        plane,
  input  afc_pkg::world_t                    w_lo [afc_pkg::NumAxes],
  input  afc_pkg::world_t                    w_hi [afc_pkg::NumAxes],
  output logic [afc_pkg::NumCorners-1:0]     corner_in
);

  afc_pkg::q88_t coef [afc_pkg::NumAxes];
  afc_pkg::q88_t d_c;
  afc_pkg::q88_t d_q;
  afc_pkg::term_t t_lo [afc_pkg::NumAxes];
  afc_pkg::term_t t_hi [afc_pkg::NumAxes];
  afc_pkg::acc_t px    [2];
  afc_pkg::acc_t pyz   [2][2];
  afc_pkg::acc_t s     [afc_pkg::NumCorners];

  always_comb begin
    for (int a = 0; a < afc_pkg::NumAxes; a++) begin
      coef[a] = $signed(plane[16*a +: 16]);
    end
    d_c = $signed(plane[63:48]);
  end

  // stage three: one product per axis and per limit
  always_ff @(posedge clk) begin
    if (pen.s3) begin
      for (int a = 0; a < afc_pkg::NumAxes; a++) begin
        t_lo[a] <= afc_pkg::term_t'(coef[a]) * afc_pkg::term_t'(w_lo[a]);
        t_hi[a] <= afc_pkg::term_t'(coef[a]) * afc_pkg::term_t'(w_hi[a]);
      end
      d_q <= d_c;
    end
  end

  // stage four: x term with offset, y plus z for the four pairings
  always_ff @(posedge clk) begin
    if (pen.s4) begin
      px[0] <= afc_pkg::acc_t'(t_lo[0]) + (afc_pkg::acc_t'(d_q) <<< afc_pkg::DShift);
      px[1] <= afc_pkg::acc_t'(t_hi[0]) + (afc_pkg::acc_t'(d_q) <<< afc_pkg::DShift);
      pyz[0][0] <= afc_pkg::acc_t'(t_lo[1]) + afc_pkg::acc_t'(t_lo[2]);
      pyz[0][1] <= afc_pkg::acc_t'(t_lo[1]) + afc_pkg::acc_t'(t_hi[2]);
      pyz[1][0] <= afc_pkg::acc_t'(t_hi[1]) + afc_pkg::acc_t'(t_lo[2]);
      pyz[1][1] <= afc_pkg::acc_t'(t_hi[1]) + afc_pkg::acc_t'(t_hi[2]);
    end
  end

  // corner k picks the high limit on axis a when bit a of k is set
  always_comb begin
    for (int k = 0; k < afc_pkg::NumCorners; k++) begin
      s[k] = px[k[0]] + pyz[k[1]][k[2]];
    end
  end

  // stage five: strictly positive test
  always_ff @(posedge clk) begin
    if (pen.s5) begin
      for (int k = 0; k < afc_pkg::NumCorners; k++) begin
        corner_in[k] <= (s[k] > 0);
      end
    end
  end

endmodule

[sv/aabb_frustum_cull_test.sv]
// top level: eight-corner box test against six frustum planes
//
//   port        dir   word
//   obj         in    position, scale and local box of one object (q8.8)
//   verdict     out   culled flag of one object
//   cfg_*       in    register writes: enable and six packed planes
//
// one object per cycle sustained unless the verdict stalls and the pipe is full
// stage depth is set by the coefficient products, 16 by 33 bits, 36 per object
// reset clears the stage valid bits, sets culling on and all planes to zero
// a stall at the verdict holds only the stages that are full: ready runs back
// stage by stage, so bubbles close up; new objects wait only when all are full
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aabb_frustum_cull_test (
  input  logic               clk,
  input  logic               rst,
  afc_obj_if.sink            obj,
  afc_verdict_if.source      verdict,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  afc_pkg::cfg_t     cfg;
  afc_pkg::pipe_en_t pen;

  // stage valid bits and the backward ready chain
  logic [afc_pkg::NumStages-1:0] vld;
  logic [afc_pkg::NumStages-1:0] rdy;

  afc_pkg::q88_t   pos [afc_pkg::NumAxes];
  afc_pkg::q88_t   scl [afc_pkg::NumAxes];
  afc_pkg::q88_t   lo  [afc_pkg::NumAxes];
  afc_pkg::q88_t   hi  [afc_pkg::NumAxes];
  afc_pkg::world_t w_lo [afc_pkg::NumAxes];
  afc_pkg::world_t w_hi [afc_pkg::NumAxes];

  logic [afc_pkg::NumPlanes-1:0][afc_pkg::NumCorners-1:0] corner_in;
  logic [afc_pkg::NumCorners-1:0] corner_vis;
  logic culled;

  afc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage takes a word when it is empty or the stage after it moves on
  always_comb begin
    rdy[afc_pkg::NumStages-1] = !vld[afc_pkg::NumStages-1] || verdict.ready;
    for (int i = afc_pkg::NumStages - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign pen.s1 = rdy[0];
  assign pen.s2 = rdy[1];
  assign pen.s3 = rdy[2];
  assign pen.s4 = rdy[3];
  assign pen.s5 = rdy[4];
  assign pen.s6 = rdy[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= obj.valid;
      end
      for (int i = 1; i < afc_pkg::NumStages; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign obj.ready = rdy[0];

  // payload in axis order x, y, z
  assign pos[0] = obj.pos_x;
  assign pos[1] = obj.pos_y;
  assign pos[2] = obj.pos_z;
  assign scl[0] = obj.scale_x;
  assign scl[1] = obj.scale_y;
  assign scl[2] = obj.scale_z;
  assign lo[0]  = obj.box_min_x;
  assign lo[1]  = obj.box_min_y;
  assign lo[2]  = obj.box_min_z;
  assign hi[0]  = obj.box_max_x;
  assign hi[1]  = obj.box_max_y;
  assign hi[2]  = obj.box_max_z;

  // stages one and two: world-space limits per axis
  afc_world u_world (
    .clk  (clk),
    .pen  (pen),
    .pos  (pos),
    .scl  (scl),
    .lo   (lo),
    .hi   (hi),
    .w_lo (w_lo),
    .w_hi (w_hi)
  );

  // stages three to five: one evaluator per plane, all corners at once
  for (genvar p = 0; p < afc_pkg::NumPlanes; p++) begin : g_plane
    afc_plane u_plane (
      .clk       (clk),
      .pen       (pen),
      .plane     (cfg.planes[p]),
      .w_lo      (w_lo),
      .w_hi      (w_hi),
      .corner_in (corner_in[p])
    );
  end

  // a corner is visible when it is inside every plane
  always_comb begin
    corner_vis = '1;
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      corner_vis = corner_vis & corner_in[p];
    end
  end

  // stage six: verdict register, also the output word
  always_ff @(posedge clk) begin
    if (pen.s6) begin
      culled <= cfg.culling_enable && !(|corner_vis);
    end
  end

  assign verdict.valid  = vld[afc_pkg::NumStages-1];
  assign verdict.culled = culled;

  // with culling off the verdict loaded is always visible
  `AFC_ASSERT_NEXT(a_off_visible, clk, rst, pen.s6 && !cfg.culling_enable, !culled)
  // full pipe with a stalled verdict must refuse new objects
  `AFC_ASSERT_NOW(a_full_refuses, clk, rst, (&vld) && !verdict.ready, !obj.ready)
  // no verdict appears without a word in stage five
  `AFC_ASSERT_NEXT(a_no_invent, clk, rst,
                   !vld[afc_pkg::NumStages-2] && !(vld[afc_pkg::NumStages-1] && !verdict.ready),
                   !vld[afc_pkg::NumStages-1])

endmodule
